>>> sv/digit_word_first_last_matcher_defines.svh
// assertion helpers for the digit word matcher
`ifndef DIGIT_WORD_FIRST_LAST_MATCHER_DEFINES_SVH
`define DIGIT_WORD_FIRST_LAST_MATCHER_DEFINES_SVH

// checked on every edge outside reset
`define DWFLM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dwflm check failed");

// checked on every edge, reset included
`define DWFLM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dwflm reset check failed");

`endif

>>> sv/dwflm_pkg.sv
`default_nettype none
package dwflm_pkg;

  // dictionary shape
  localparam int PAT_COUNT   = 18;
  localparam int PAT_LEN_MAX = 5;
  localparam int HIST_DEPTH  = PAT_LEN_MAX - 1;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] digit_t;
  typedef byte_t pat_text_t [PAT_LEN_MAX];

  // pattern text, last character first, unused tail is zero
  localparam pat_text_t PAT_REV [PAT_COUNT] = '{
    '{"1", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"2", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"3", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"4", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"5", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"6", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"7", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"8", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"9", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "n", "o", 8'h00, 8'h00},
    '{"o", "w", "t", 8'h00, 8'h00},
    '{"e", "e", "r", "h", "t"},
    '{"r", "u", "o", "f", 8'h00},
    '{"e", "v", "i", "f", 8'h00},
    '{"x", "i", "s", 8'h00, 8'h00},
    '{"n", "e", "v", "e", "s"},
    '{"t", "h", "g", "i", "e"},
    '{"e", "n", "i", "n", 8'h00}
  };

  localparam int PAT_LEN [PAT_COUNT] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1, 3, 3, 5, 4, 4, 3, 5, 5, 4
  };

  localparam digit_t PAT_VAL [PAT_COUNT] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
    4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
  };

  // control handed from the top level to every history cell
  typedef struct packed {
    logic shift;
    logic clear;
  } dwflm_ctl_t;

  // one result word
  typedef struct packed {
    digit_t     first_digit;
    digit_t     last_digit;
    logic [6:0] line_value;
    logic       found;
  } dwflm_res_t;

endpackage
`default_nettype wire

>>> sv/dwflm_cell.sv
`default_nettype none
module dwflm_cell (
  input  wire                   clk,
  input  wire                   rst,
  input  dwflm_pkg::dwflm_ctl_t ctl,
  input  wire  [7:0]            d,
  input  wire                   d_valid,
  output logic [7:0]            q,
  output logic                  q_valid
);
  import dwflm_pkg::*;

  // one character of line history, handed on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (ctl.shift) begin
      q_valid <= d_valid & ~ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

>>> sv/dwflm_match.sv
`default_nettype none
module dwflm_match (
  input  dwflm_pkg::byte_t                       window [dwflm_pkg::PAT_LEN_MAX],
  input  wire  [dwflm_pkg::PAT_LEN_MAX-1:0]      window_valid,
  output dwflm_pkg::digit_t                      hit
);
  import dwflm_pkg::*;

  // compare every pattern against the tail of the line, at most one hits
  always_comb begin
    logic eq;
    hit = '0;
    for (int p = 0; p < PAT_COUNT; p++) begin
      eq = 1'b1;
      for (int k = 0; k < PAT_LEN_MAX; k++) begin
        if (k < PAT_LEN[p]) begin
          eq = eq & window_valid[k] & (window[k] == PAT_REV[p][k]);
        end
      end
      if (eq) begin
        hit = hit | PAT_VAL[p];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/digit_word_first_last_matcher.sv
`default_nettype none
// Finds the first and last digit of a text line, where a digit is either
// "1".."9" or one of the words "one".."nine", overlaps allowed. One byte is
// taken per cycle unless in_stall is set, and is compared in the same cycle
// against a chain of four history cells holding the previous bytes of the
// line, and the cells shift by one on every accepted word. A word with
// line_end set produces one result word, registered into a two-entry
// output buffer (first_digit, last_digit, line_value = 10*first+last,
// found; all zero if nothing matched), and the history is emptied for the
// next line. Input stalls only while two results wait in that buffer.
module digit_word_first_last_matcher (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] symbol,
  input  wire        line_end,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [3:0] first_digit,
  output logic [3:0] last_digit,
  output logic [6:0] line_value,
  output logic       found
);
  import dwflm_pkg::*;

  dwflm_ctl_t ctl;
  byte_t      hist [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_valid;
  byte_t      window [PAT_LEN_MAX];
  logic [PAT_LEN_MAX-1:0] window_valid;
  digit_t     hit;
  digit_t     first_seen, first_seen_next;
  digit_t     latest_seen, latest_seen_next;
  dwflm_res_t res_new;
  dwflm_res_t res_out, res_skid;
  logic       skid_valid;
  logic       accept, push, out_take;

  // handshake
  assign accept   = in_valid & ~in_stall;
  assign push     = accept & line_end;
  assign out_take = out_valid & ~out_stall;
  assign in_stall = skid_valid;

  assign ctl.shift = accept;
  assign ctl.clear = line_end;

  // history chain, newest byte in cell zero
  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      dwflm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .d       (symbol),
        .d_valid (1'b1),
        .q       (hist[i]),
        .q_valid (hist_valid[i])
      );
    end else begin : g_body
      dwflm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .d       (hist[i-1]),
        .d_valid (hist_valid[i-1]),
        .q       (hist[i]),
        .q_valid (hist_valid[i])
      );
    end
  end

  // match window: incoming byte plus history
  always_comb begin
    window[0] = symbol;
    for (int k = 1; k < PAT_LEN_MAX; k++) begin
      window[k] = hist[k-1];
    end
  end
  assign window_valid = {hist_valid, 1'b1};

  dwflm_match u_match (
    .window       (window),
    .window_valid (window_valid),
    .hit          (hit)
  );

  // first and latest match of the line
  always_comb begin
    first_seen_next  = first_seen;
    latest_seen_next = latest_seen;
    if (hit != '0) begin
      if (first_seen == '0) begin
        first_seen_next = hit;
      end
      latest_seen_next = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen  <= '0;
      latest_seen <= '0;
    end else if (accept) begin
      if (line_end) begin
        first_seen  <= '0;
        latest_seen <= '0;
      end else begin
        first_seen  <= first_seen_next;
        latest_seen <= latest_seen_next;
      end
    end
  end

  // result word, ten times first by shift and add
  always_comb begin
    res_new.first_digit = first_seen_next;
    res_new.last_digit  = latest_seen_next;
    res_new.line_value  = {first_seen_next, 3'b000} + {2'b00, first_seen_next, 1'b0}
                        + {3'b000, latest_seen_next};
    res_new.found       = first_seen_next != '0;
  end

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid & ~out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        res_out <= res_skid;
      end
    end else if (push) begin
      if (out_valid & ~out_take) begin
        res_skid <= res_new;
      end else begin
        res_out <= res_new;
      end
    end
  end

  assign first_digit = res_out.first_digit;
  assign last_digit  = res_out.last_digit;
  assign line_value  = res_out.line_value;
  assign found       = res_out.found;

endmodule
`default_nettype wire

>>> sv/dwflm_checker.sv
`default_nettype none
`include "digit_word_first_last_matcher_defines.svh"
module dwflm_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_stall,
  input wire [7:0] symbol,
  input wire       line_end,
  input wire       out_valid,
  input wire       out_stall,
  input wire [3:0] first_digit,
  input wire [3:0] last_digit,
  input wire [6:0] line_value,
  input wire       found
);

  // a stalled input word holds
  `DWFLM_ASSERT(a_in_hold,
    in_valid && in_stall |=> in_valid && $stable(symbol) && $stable(line_end))

  // a stalled result word keeps its line value and found flag
  `DWFLM_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(line_value) && $stable(found))

  // line value agrees with the two digits
  `DWFLM_ASSERT(a_value,
    out_valid |-> line_value == ({3'b000, first_digit} * 7'd10 + {3'b000, last_digit}))

  // found agrees with both digits being nonzero or both zero
  `DWFLM_ASSERT(a_found,
    out_valid |-> (found == (first_digit != 4'd0)) && (found == (last_digit != 4'd0)))

  // after reset no result is shown and input is open
  `DWFLM_ASSERT_RST(a_reset, rst |=> !out_valid && !in_stall)

endmodule

bind digit_word_first_last_matcher dwflm_checker u_dwflm_checker (.*);
`default_nettype wire

>>> tb/sv/digit_word_first_last_matcher_test.sv
module digit_word_first_last_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1900;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;

  // one expected line result
  typedef struct {
    logic [3:0] first_digit;
    logic [3:0] last_digit;
    logic [6:0] line_value;
    logic       found;
  } line_result_t;

  // one directed word, with a typed result where it is obvious
  typedef struct {
    logic [7:0] symbol;
    logic       line_end;
    logic       typed;
    logic [3:0] first_digit;
    logic [3:0] last_digit;
    logic [6:0] line_value;
    logic       found;
  } directed_word_t;

  // segment kinds of a random line
  typedef enum int {
    SEG_WORD, SEG_DIGIT, SEG_PREFIX, SEG_LETTER, SEG_NOISE
  } segment_kind_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] symbol = 8'h00;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] first_digit;
  logic [3:0] last_digit;
  logic [6:0] line_value;
  logic       found;

  digit_word_first_last_matcher dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .symbol      (symbol),
    .line_end    (line_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .first_digit (first_digit),
    .last_digit  (last_digit),
    .line_value  (line_value),
    .found       (found)
  );

  // spelled digits, value is index plus one
  string spelled [9] = '{"one", "two", "three", "four", "five",
                         "six", "seven", "eight", "nine"};
  string letters = "efghinorstuvwx";

  directed_word_t directed_words [23] = '{
    '{"x",   1'b1, 1'b1, 4'd0, 4'd0, 7'd0,  1'b0},
    '{8'h00, 1'b1, 1'b1, 4'd0, 4'd0, 7'd0,  1'b0},
    '{8'hFF, 1'b1, 1'b1, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"1",   1'b1, 1'b1, 4'd1, 4'd1, 7'd11, 1'b1},
    '{"9",   1'b1, 1'b1, 4'd9, 4'd9, 7'd99, 1'b1},
    '{"e",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"i",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"g",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"h",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"t",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"w",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"o",   1'b1, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"t",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"h",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"r",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"e",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"e",   1'b1, 1'b1, 4'd3, 4'd3, 7'd33, 1'b1},
    '{"o",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"n",   1'b1, 1'b1, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"e",   1'b1, 1'b1, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"7",   1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{8'h80, 1'b0, 1'b0, 4'd0, 4'd0, 7'd0,  1'b0},
    '{"n",   1'b1, 1'b1, 4'd7, 4'd7, 7'd77, 1'b1}
  };

  // matcher shadow state: last five bytes of the line
  logic [39:0]  recent_bytes = '0;
  int unsigned  recent_count = 0;
  logic [3:0]   first_seen = '0;
  logic [3:0]   latest_seen = '0;

  line_result_t line_results_due [$];
  logic [7:0]   line_bytes [$];

  int errors = 0;
  int words_sent = 0;
  int lines_sent = 0;
  int lines_matched = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // value of the dictionary entry ending at the newest byte, 0 if none
  function automatic logic [3:0] ending_value();
    int unsigned len;
    bit          hit;
    if (recent_bytes[7:0] >= "1" && recent_bytes[7:0] <= "9")
      return 4'(recent_bytes[7:0] - "0");
    for (int w = 0; w < 9; w++) begin
      len = spelled[w].len();
      if (recent_count >= len) begin
        hit = 1'b1;
        for (int k = 0; k < len; k++)
          if (recent_bytes[8 * (len - 1 - k) +: 8] != spelled[w][k])
            hit = 1'b0;
        if (hit)
          return 4'(w + 1);
      end
    end
    return 4'd0;
  endfunction

  // advance the shadow matcher by one accepted word
  task automatic score_symbol(input logic [7:0] sym, input logic last,
                              output bit line_done, output line_result_t res);
    logic [3:0] hit;
    recent_bytes = {recent_bytes[31:0], sym};
    if (recent_count < 5)
      recent_count++;
    hit = ending_value();
    if (hit != 4'd0) begin
      if (first_seen == 4'd0)
        first_seen = hit;
      latest_seen = hit;
    end
    line_done = last;
    res.first_digit = first_seen;
    res.last_digit  = latest_seen;
    res.line_value  = 7'(first_seen * 10 + latest_seen);
    res.found       = (first_seen != 4'd0);
    if (last) begin
      if (res.found)
        lines_matched++;
      lines_sent++;
      recent_bytes = '0;
      recent_count = 0;
      first_seen   = '0;
      latest_seen  = '0;
    end
  endtask

  // offer one word after a random gap, return once it is taken
  int send_calm = 0;
  task automatic send_word(input logic [7:0] sym, input logic last);
    int gap;
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 49) == 0)
        send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= sym;
    line_end <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  // random line built from words, digits, partial words, letters and noise
  task automatic make_line();
    int            segments;
    int            w;
    int            n;
    int            pick;
    segment_kind_t kind;
    line_bytes.delete();
    segments = $urandom_range(1, 4);
    for (int s = 0; s < segments; s++) begin
      pick = $urandom_range(0, 99);
      kind = pick < 35 ? SEG_WORD : pick < 50 ? SEG_DIGIT : pick < 65 ? SEG_PREFIX :
             pick < 85 ? SEG_LETTER : SEG_NOISE;
      w = $urandom_range(0, 8);
      case (kind)
        SEG_WORD: begin
          for (int k = 0; k < spelled[w].len(); k++)
            line_bytes.push_back(spelled[w][k]);
        end
        SEG_DIGIT: begin
          line_bytes.push_back(8'("1" + w));
        end
        SEG_PREFIX: begin
          n = $urandom_range(1, spelled[w].len() - 1);
          for (int k = 0; k < n; k++)
            line_bytes.push_back(spelled[w][k]);
        end
        SEG_LETTER: begin
          line_bytes.push_back(letters[$urandom_range(0, letters.len() - 1)]);
        end
        default: begin
          line_bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // reset, directed words, random lines, then drain
  initial begin
    bit           line_done;
    line_result_t res;
    line_result_t typed_res;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_words[i]) begin
      send_word(directed_words[i].symbol, directed_words[i].line_end);
      score_symbol(directed_words[i].symbol, directed_words[i].line_end, line_done, res);
      if (line_done) begin
        if (directed_words[i].typed) begin
          typed_res.first_digit = directed_words[i].first_digit;
          typed_res.last_digit  = directed_words[i].last_digit;
          typed_res.line_value  = directed_words[i].line_value;
          typed_res.found       = directed_words[i].found;
          line_results_due.push_back(typed_res);
        end else begin
          line_results_due.push_back(res);
        end
      end
    end

    while (words_sent < RANDOM_WORDS + $size(directed_words)) begin
      make_line();
      foreach (line_bytes[i]) begin
        send_word(line_bytes[i], i == line_bytes.size() - 1);
        score_symbol(line_bytes[i], i == line_bytes.size() - 1, line_done, res);
        if (line_done)
          line_results_due.push_back(res);
      end
    end
    in_valid <= 1'b0;

    while (line_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words in %0d lines, %0d of them with a digit match",
             words_sent, lines_sent, lines_matched);
    $display("checked %0d line results field by field", results_seen);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side stalls, with long holds so the input backs up
  initial begin
    int hold_at;
    int stall;
    int calm;
    hold_at = 150;
    calm = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (results_seen >= hold_at) begin
        hold_at += 500;
        stall = HOLD_CYCLES;
      end else if (calm > 0) begin
        stall = 0;
        calm--;
      end else begin
        stall = $urandom_range(0, 10);
        if ($urandom_range(0, 49) == 0)
          calm = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_stall <= 1'b1;
        repeat (stall) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  // compare each taken result word with the oldest expectation
  always @(negedge clk) begin
    line_result_t due;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (line_results_due.size() == 0) begin
        $error("result word with no line pending: first_digit %0d last_digit %0d",
               first_digit, last_digit);
        errors++;
      end else begin
        due = line_results_due.pop_front();
        if (first_digit !== due.first_digit) begin
          $error("first_digit: expected %0d, got %0d", due.first_digit, first_digit);
          errors++;
        end
        if (last_digit !== due.last_digit) begin
          $error("last_digit: expected %0d, got %0d", due.last_digit, last_digit);
          errors++;
        end
        if (line_value !== due.line_value) begin
          $error("line_value: expected %0d, got %0d", due.line_value, line_value);
          errors++;
        end
        if (found !== due.found) begin
          $error("found: expected %0d, got %0d", due.found, found);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(negedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d lines still due",
                 idle_cycles, line_results_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
